// ----- rtl/cswq_pkg.sv -----
// Shared types for the counting semaphore wait queue unit.
// Request kinds, result status codes, controller states and the
// command and status bundles between controller and datapath.
`default_nettype none

package cswq_pkg;

   typedef enum logic [1:0] {
      KIND_WAIT    = 2'd0,
      KIND_POST    = 2'd1,
      KIND_TIMEOUT = 2'd2,
      KIND_DELETE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_GRANTED     = 3'd0,
      STAT_QUEUED      = 3'd1,
      STAT_UNAVAILABLE = 3'd2,
      STAT_WOKEN       = 3'd3,
      STAT_RAISED      = 3'd4,
      STAT_TIMED_OUT   = 3'd5,
      STAT_RELEASED    = 3'd6
   } status_type;

   // Queue position that the shared address adder works on.
   typedef enum logic [1:0] {
      POS_IDX  = 2'd0,
      POS_NEXT = 2'd1,
      POS_LEN  = 2'd2
   } pos_type;

   typedef enum logic [2:0] {
      S_IDLE      = 3'd0,
      S_DISPATCH  = 3'd1,
      S_POST_OUT  = 3'd2,
      S_TMO_CMP   = 3'd3,
      S_SHIFT_CHK = 3'd4,
      S_SHIFT_WR  = 3'd5,
      S_TMO_EMIT  = 3'd6,
      S_DEL_OUT   = 3'd7
   } state_type;

   typedef struct packed {
      logic    take_req;
      logic    do_wait;
      logic    post_empty;
      logic    post_pop;
      logic    tmo_emit;
      logic    del_emit;
      logic    reload;
      logic    idx_inc;
      logic    rd_en;
      logic    wr_shift;
      pos_type pos_sel;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     len_zero;
      logic     idx_last;
      logic     match;
      logic     out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/cswq_ram.sv -----
// Generic single-port RAM with a registered read.
// No dependencies; the read register holds when no read is issued.
`default_nettype none

module cswq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cswq_datapath.sv -----
// Datapath: count, circular wait queue in RAM, request and result registers.
// Uses cswq_pkg and cswq_ram; driven by commands from cswq_controller.
`default_nettype none

module cswq_datapath #(
   parameter int MAX_TASKS   = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [7:0]       csr_wdata,
   input  wire logic [7:0]       req_tdata,
   input  wire logic [1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [7:0]       rsp_tdata,
   output logic      [2:0]       rsp_tuser,
   output logic                  rsp_tlast,
   input  wire cswq_pkg::cmd_type  cmd,
   output      cswq_pkg::stat_type stat
);

   localparam int AW = $clog2(MAX_TASKS);
   localparam int LW = $clog2(MAX_TASKS + 1);
   localparam logic signed [COUNT_WIDTH-1:0] CNT_TOP =
      {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_BOTTOM =
      {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic signed [COUNT_WIDTH-1:0] CNT_ZERO = '0;
   localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE  = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   logic [7:0]                     init_ff, init_in;
   logic signed [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [AW-1:0]                  head_ff, head_in;
   logic [LW-1:0]                  len_ff, len_in;
   logic [AW-1:0]                  idx_ff, idx_in;

   cswq_pkg::kind_type             kind_ff, kind_in;
   logic [3:0]                     task_ff, task_in;
   logic                           may_wait_ff, may_wait_in;

   logic                           valid_ff, valid_in;
   cswq_pkg::status_type           status_ff, status_in;
   logic [3:0]                     woken_ff, woken_in;
   logic                           last_ff, last_in;

   logic [LW-1:0]                  idx_p1;
   logic [AW-1:0]                  pos;
   logic [AW:0]                    addr_sum;
   logic [AW-1:0]                  addr;
   logic [3:0]                     rd_data;
   logic                           wr_en;
   logic [3:0]                     wr_data;

   logic                           granted;
   logic                           will_queue;
   logic                           idx_last;
   logic                           out_free;
   logic                           emit;
   logic signed [COUNT_WIDTH-1:0]  count_raised;
   logic signed [COUNT_WIDTH-1:0]  load_value;
   logic [COUNT_WIDTH:0]           init_wide;

   // Queue position to RAM address: head plus offset, wrapped once.
   assign idx_p1 = LW'(idx_ff) + LW'(1);

   always_comb begin
      unique case (cmd.pos_sel)
         cswq_pkg::POS_IDX:  pos = idx_ff;
         cswq_pkg::POS_NEXT: pos = idx_p1[AW-1:0];
         cswq_pkg::POS_LEN:  pos = len_ff[AW-1:0];
         default:            pos = idx_ff;
      endcase
      addr_sum = {1'b0, head_ff} + {1'b0, pos};
      if (addr_sum >= (AW+1)'(MAX_TASKS)) begin
         addr_sum = addr_sum - (AW+1)'(MAX_TASKS);
      end
      addr = addr_sum[AW-1:0];
   end

   assign granted    = count_ff > CNT_ZERO;
   assign will_queue = !granted && may_wait_ff && (len_ff != LW'(MAX_TASKS))
                       && (count_ff != CNT_BOTTOM);
   assign idx_last   = idx_p1 == len_ff;
   assign out_free   = !valid_ff || rsp_tready;
   assign emit       = cmd.do_wait || cmd.post_empty || cmd.post_pop
                       || cmd.tmo_emit || cmd.del_emit;

   assign count_raised = (count_ff != CNT_TOP) ? count_ff + CNT_ONE : count_ff;
   assign init_wide    = (COUNT_WIDTH+1)'(init_ff);
   assign load_value   = (init_wide > {1'b0, CNT_TOP}) ? CNT_TOP
                                                        : init_wide[COUNT_WIDTH-1:0];

   assign wr_en   = cmd.wr_shift || (cmd.do_wait && will_queue);
   assign wr_data = cmd.wr_shift ? rd_data : task_ff;

   cswq_ram #(
      .WIDTH (4),
      .DEPTH (MAX_TASKS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (cmd.rd_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_comb begin
      init_in     = csr_we ? csr_wdata : init_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      kind_in     = kind_ff;
      task_in     = task_ff;
      may_wait_in = may_wait_ff;
      valid_in    = valid_ff && !rsp_tready;
      status_in   = status_ff;
      woken_in    = woken_ff;
      last_in     = last_ff;

      if (cmd.take_req) begin
         kind_in     = cswq_pkg::kind_type'(req_tuser);
         task_in     = req_tdata[3:0];
         may_wait_in = req_tdata[4];
         idx_in      = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_p1[AW-1:0];
      end

      if (emit) begin
         valid_in = 1'b1;
         woken_in = 4'd0;
         last_in  = 1'b1;
      end

      if (cmd.do_wait) begin
         if (granted) begin
            count_in  = count_ff - CNT_ONE;
            status_in = cswq_pkg::STAT_GRANTED;
         end else if (will_queue) begin
            count_in  = count_ff - CNT_ONE;
            len_in    = len_ff + LW'(1);
            status_in = cswq_pkg::STAT_QUEUED;
         end else begin
            status_in = cswq_pkg::STAT_UNAVAILABLE;
         end
      end

      if (cmd.post_empty) begin
         count_in  = count_raised;
         status_in = cswq_pkg::STAT_RAISED;
      end

      if (cmd.post_pop) begin
         count_in  = count_raised;
         len_in    = len_ff - LW'(1);
         head_in   = (head_ff == AW'(MAX_TASKS - 1)) ? '0 : head_ff + AW'(1);
         status_in = cswq_pkg::STAT_WOKEN;
         woken_in  = rd_data;
      end

      if (cmd.tmo_emit) begin
         count_in  = count_raised;
         len_in    = len_ff - LW'(1);
         status_in = cswq_pkg::STAT_TIMED_OUT;
         woken_in  = task_ff;
      end

      if (cmd.del_emit) begin
         status_in = cswq_pkg::STAT_RELEASED;
         woken_in  = rd_data;
         last_in   = idx_last;
      end

      // Delete ends by emptying the queue and reloading the count.
      if (cmd.reload || (cmd.del_emit && idx_last)) begin
         count_in = load_value;
         len_in   = '0;
         head_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= 8'd1;
         count_ff <= CNT_ONE;
         head_ff  <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         init_ff  <= init_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      task_ff     <= task_in;
      may_wait_ff <= may_wait_in;
      status_ff   <= status_in;
      woken_ff    <= woken_in;
      last_ff     <= last_in;
   end

   assign stat.kind     = kind_ff;
   assign stat.len_zero = len_ff == '0;
   assign stat.idx_last = idx_last;
   assign stat.match    = rd_data == task_ff;
   assign stat.out_free = out_free;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, woken_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   // A negative count stands for exactly the number of waiting tasks.
   a_count_tracks_len: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> ((count_ff + COUNT_WIDTH'(len_ff)) == CNT_ZERO))
      else $error("count does not match queue length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LW'(MAX_TASKS)) && (head_ff <= AW'(MAX_TASKS - 1)))
      else $error("queue length or head out of range");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded while output register is occupied");

   a_queue_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_wait && will_queue) |=> (len_ff == $past(len_ff) + LW'(1)))
      else $error("queued wait did not extend the queue");

endmodule

`default_nettype wire

// ----- rtl/cswq_controller.sv -----
// Controller state machine for the counting semaphore wait queue unit.
// Uses cswq_pkg; issues commands to cswq_datapath and reads its status.
`default_nettype none

module cswq_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire cswq_pkg::stat_type stat,
   output      cswq_pkg::cmd_type  cmd
);

   cswq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cswq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cswq_pkg::S_IDLE: begin
            if (req_tvalid) state_in = cswq_pkg::S_DISPATCH;
         end
         cswq_pkg::S_DISPATCH: begin
            unique case (stat.kind)
               cswq_pkg::KIND_WAIT: begin
                  if (stat.out_free) state_in = cswq_pkg::S_IDLE;
               end
               cswq_pkg::KIND_POST: begin
                  if (!stat.len_zero)    state_in = cswq_pkg::S_POST_OUT;
                  else if (stat.out_free) state_in = cswq_pkg::S_IDLE;
               end
               cswq_pkg::KIND_TIMEOUT: begin
                  state_in = stat.len_zero ? cswq_pkg::S_IDLE : cswq_pkg::S_TMO_CMP;
               end
               cswq_pkg::KIND_DELETE: begin
                  state_in = stat.len_zero ? cswq_pkg::S_IDLE : cswq_pkg::S_DEL_OUT;
               end
               default: state_in = cswq_pkg::S_IDLE;
            endcase
         end
         cswq_pkg::S_POST_OUT: begin
            if (stat.out_free) state_in = cswq_pkg::S_IDLE;
         end
         cswq_pkg::S_TMO_CMP: begin
            if (stat.match)         state_in = cswq_pkg::S_SHIFT_CHK;
            else if (stat.idx_last) state_in = cswq_pkg::S_IDLE;
         end
         cswq_pkg::S_SHIFT_CHK: begin
            state_in = stat.idx_last ? cswq_pkg::S_TMO_EMIT : cswq_pkg::S_SHIFT_WR;
         end
         cswq_pkg::S_SHIFT_WR: begin
            state_in = cswq_pkg::S_SHIFT_CHK;
         end
         cswq_pkg::S_TMO_EMIT: begin
            if (stat.out_free) state_in = cswq_pkg::S_IDLE;
         end
         cswq_pkg::S_DEL_OUT: begin
            if (stat.out_free && stat.idx_last) state_in = cswq_pkg::S_IDLE;
         end
         default: state_in = cswq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.pos_sel = cswq_pkg::POS_IDX;
      req_tready = 1'b0;
      unique case (state_ff)
         cswq_pkg::S_IDLE: begin
            req_tready   = 1'b1;
            cmd.take_req = req_tvalid;
         end
         cswq_pkg::S_DISPATCH: begin
            unique case (stat.kind)
               cswq_pkg::KIND_WAIT: begin
                  cmd.do_wait = stat.out_free;
                  cmd.pos_sel = cswq_pkg::POS_LEN;
               end
               cswq_pkg::KIND_POST: begin
                  cmd.post_empty = stat.len_zero && stat.out_free;
                  cmd.rd_en      = !stat.len_zero;
               end
               cswq_pkg::KIND_TIMEOUT: begin
                  cmd.rd_en = !stat.len_zero;
               end
               cswq_pkg::KIND_DELETE: begin
                  cmd.reload = stat.len_zero;
                  cmd.rd_en  = !stat.len_zero;
               end
               default: ;
            endcase
         end
         cswq_pkg::S_POST_OUT: begin
            cmd.post_pop = stat.out_free;
         end
         cswq_pkg::S_TMO_CMP: begin
            // Step to the next entry while the current one does not match.
            if (!stat.match && !stat.idx_last) begin
               cmd.rd_en   = 1'b1;
               cmd.idx_inc = 1'b1;
               cmd.pos_sel = cswq_pkg::POS_NEXT;
            end
         end
         cswq_pkg::S_SHIFT_CHK: begin
            if (!stat.idx_last) begin
               cmd.rd_en   = 1'b1;
               cmd.pos_sel = cswq_pkg::POS_NEXT;
            end
         end
         cswq_pkg::S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         cswq_pkg::S_TMO_EMIT: begin
            cmd.tmo_emit = stat.out_free;
         end
         cswq_pkg::S_DEL_OUT: begin
            if (stat.out_free) begin
               cmd.del_emit = 1'b1;
               if (!stat.idx_last) begin
                  cmd.rd_en   = 1'b1;
                  cmd.idx_inc = 1'b1;
                  cmd.pos_sel = cswq_pkg::POS_NEXT;
               end
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/counting_semaphore_wait_queue_unit.sv -----
// Top level of the counting semaphore with a FIFO wait queue.
// Instantiates cswq_controller and cswq_datapath; types from cswq_pkg.
//
//   channel  direction  signals                              contents
//   req      in         req_tvalid/tready/tdata/tuser         one request
//   rsp      out        rsp_tvalid/tready/tdata/tuser/tlast   one result
//   csr      in         csr_we/csr_wdata                      initial count
//
// A request is taken in the idle state and sorted by kind in the dispatch
// state: wait and an empty post answer there, a post with waiters reads the
// queue head first. A timeout reads the queue one entry a cycle, then closes
// the gap behind the match. A delete gives one release a cycle while the
// output is free. The single-port queue RAM serializes these steps.
// Reset is synchronous and needs no clearing pass; the count starts at 1.
// A stalled result holds in the output register and the controller waits.
`default_nettype none

module counting_semaphore_wait_queue_unit #(
   parameter int MAX_TASKS   = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [3:0] task_id, [4] may_wait, [7:5] zero
   input  wire logic [1:0] req_tuser,   // [1:0] kind
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [3:0] woken_task, [7:4] zero
   output logic      [2:0] rsp_tuser,   // [2:0] status
   output logic            rsp_tlast
);

   cswq_pkg::cmd_type  cmd;
   cswq_pkg::stat_type stat;

   cswq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cswq_datapath #(
      .MAX_TASKS   (MAX_TASKS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire
